// ===== rtl/f2u8s_pkg.sv =====
// ----------------------------------------------------------------------------
// f2u8s_pkg: shared types and threshold tables for the unorm8 / sRGB encoder
// payload structs, and the two 256-entry threshold tables built at elaboration
// ----------------------------------------------------------------------------
package f2u8s_pkg;

   typedef struct packed {
      logic [31:0] sample_bits;
      logic        last_in;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] code_out;
      logic       last_out;
   } rsp_payload_type;

   typedef logic [31:0]  thresh_type;
   typedef thresh_type   thresh_table_type [256];
   typedef logic [383:0] big_type;

   // binary32 pattern of 1.0, every code is met here
   localparam thresh_type ONE_BITS = 32'h3F80_0000;

   function automatic big_type big_pow(big_type base, int n);
      big_type r;
      r = big_type'(1);
      for (int i = 0; i < n; i++) begin
         r = r * base;
      end
      return r;
   endfunction

   // m^5 * 53805^12 >= (200k + 2705)^12 * 2^(5*neg_e)
   function automatic bit power_meets(logic [23:0] m, int neg_e, int k, big_type c12);
      big_type a;
      big_type b;
      a = big_pow(big_type'(m), 5) * c12;
      b = big_pow(big_type'(200 * k + 2705), 12);
      b = b << (5 * neg_e);
      return a >= b;
   endfunction

   function automatic int lin_code(logic [23:0] m, int neg_e);
      logic [63:0] p;
      logic [63:0] q;
      logic [63:0] rem;
      logic [63:0] half;
      int          len;
      int          s;
      int          sh;
      if (m == 24'd0) begin
         return 0;
      end
      p   = 64'(m) * 64'd255;
      len = 0;
      while (len < 64 && (p >> len) != 64'd0) begin
         len++;
      end
      s = (len > 24) ? len - 24 : 0;
      q = p >> s;
      if (s > 0) begin
         rem  = p & ((64'd1 << s) - 64'd1);
         half = 64'd1 << (s - 1);
         if (rem > half || (rem == half && q[0])) begin
            q = q + 64'd1;
         end
      end
      sh = neg_e - s;
      if (sh <= 0) begin
         return (q > 64'd255) ? 255 : int'(q[8:0]);
      end
      if (sh > 40) begin
         return 0;
      end
      q = (q + (64'd1 << (sh - 1))) >> sh;
      return (q > 64'd255) ? 255 : int'(q[8:0]);
   endfunction

   function automatic bit srgb_meets(logic [23:0] m, int neg_e, int k, big_type c12);
      bit          low_seg;
      logic [63:0] n;
      logic [63:0] d;
      if (m == 24'd0) begin
         return 1'b0;
      end
      if (neg_e >= 40) begin
         low_seg = 1'b1;
      end else begin
         low_seg = (64'(m) * 64'd10000000) <= (64'd31308 << neg_e);
      end
      if (low_seg) begin
         if (neg_e >= 37) begin
            return 1'b0;
         end
         n = 64'(m) * 64'd32946;
         d = 64'd10 << neg_e;
         // rounded x*3294.6 >= k, written without the divide
         return (64'd2 * n + d) >= (64'd2 * d * 64'(k));
      end
      return power_meets(m, neg_e, k, c12);
   endfunction

   // true when the code of nonnegative pattern p is at least k (k >= 1)
   function automatic bit code_meets(bit srgb, thresh_type p, int k, big_type c12);
      logic [23:0] m;
      int          neg_e;
      if (p >= ONE_BITS) begin
         return 1'b1;
      end
      if (p[30:23] == 8'd0) begin
         m     = {1'b0, p[22:0]};
         neg_e = 149;
      end else begin
         m     = {1'b1, p[22:0]};
         neg_e = 150 - int'(p[30:23]);
      end
      if (srgb) begin
         return srgb_meets(m, neg_e, k, c12);
      end
      return lin_code(m, neg_e) >= k;
   endfunction

   // entry k: smallest pattern whose code is k or more
   function automatic thresh_table_type build_table(bit srgb);
      thresh_table_type t;
      big_type          c12;
      thresh_type       lo;
      thresh_type       hi;
      thresh_type       mid;
      c12  = big_pow(big_type'(53805), 12);
      t[0] = '0;
      for (int k = 1; k < 256; k++) begin
         if (k > 1 && code_meets(srgb, t[k-1], k, c12)) begin
            t[k] = t[k-1];
         end else begin
            lo = (k > 1) ? t[k-1] : '0;
            hi = ONE_BITS;
            while (hi - lo > 32'd1) begin
               mid = lo + ((hi - lo) >> 1);
               if (code_meets(srgb, mid, k, c12)) begin
                  hi = mid;
               end else begin
                  lo = mid;
               end
            end
            t[k] = hi;
         end
      end
      return t;
   endfunction

   localparam thresh_table_type LINEAR_TABLE = build_table(1'b0);
   localparam thresh_table_type SRGB_TABLE   = build_table(1'b1);

endpackage

// ===== rtl/float_to_unorm8_srgb_encode_core.sv =====
// ----------------------------------------------------------------------------
// float_to_unorm8_srgb_encode_core: binary32 channel sample to unorm8 / sRGB8
// linear quantize or sRGB transfer encode, selected by a control bit
// ----------------------------------------------------------------------------
// order: the input transfer loads the input reg, then the result reg holds the code
// throughput: one sample per cycle; a stalled result holds, the input reg
//   keeps taking samples until both registers are full
// reset (synchronous, active high): empties both registers, srgb_mode to 0
// the path between the registers is the threshold compare in f2u8s_encode
module float_to_unorm8_srgb_encode_core
   import f2u8s_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   // input channel
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   // result channel
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload,
   // control register
   input  logic            csr_wr_en,
   input  logic            csr_wr_data
);

   // mode register
   logic csr_srgb_mode_ff;
   logic csr_srgb_mode_in;

   // input register
   logic            s1_valid_ff;
   logic            s1_valid_in;
   req_payload_type s1_payload_ff;
   req_payload_type s1_payload_in;

   // result register
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   rsp_payload_type rsp_payload_ff;
   rsp_payload_type rsp_payload_in;

   logic       s1_advance;
   logic [7:0] enc_code;

   // to be written by the user only while idle (the block does not enforce it), so it is read live
   assign csr_srgb_mode_in = csr_wr_en ? csr_wr_data : csr_srgb_mode_ff;

   // result reg can take a new value when empty or being drained
   assign s1_advance = !rsp_valid_ff || rsp_ready;
   // input reg can take a transfer when empty or moving on
   assign req_ready  = !s1_valid_ff || s1_advance;

   always_comb begin
      s1_valid_in   = s1_valid_ff;
      s1_payload_in = s1_payload_ff;
      if (req_ready) begin
         s1_valid_in   = req_valid;
         s1_payload_in = req_payload;
      end
   end

   f2u8s_encode u_encode (
      .sample_bits (s1_payload_ff.sample_bits),
      .srgb_mode   (csr_srgb_mode_ff),
      .code        (enc_code)
   );

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (s1_advance) begin
         rsp_valid_in            = s1_valid_ff;
         rsp_payload_in.code_out = enc_code;
         rsp_payload_in.last_out = s1_payload_ff.last_in;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_srgb_mode_ff <= 1'b0;
         s1_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         csr_srgb_mode_ff <= csr_srgb_mode_in;
         s1_valid_ff      <= s1_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      s1_payload_ff  <= s1_payload_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// ===== rtl/f2u8s_encode.sv =====
// ----------------------------------------------------------------------------
// f2u8s_encode: sample to 8-bit code
// parallel compare against every threshold of the selected mode
// ----------------------------------------------------------------------------
module f2u8s_encode
   import f2u8s_pkg::*;
(
   input  logic [31:0] sample_bits,
   input  logic        srgb_mode,
   output logic [7:0]  code
);

   logic zero_code;

   // negatives and nan give code 0
   assign zero_code = sample_bits[31] ||
                      (sample_bits[30:23] == 8'hFF && sample_bits[22:0] != 23'd0);

   always_comb begin
      logic [7:0] acc;
      thresh_type thr;
      acc = '0;
      // thresholds ascend with k, so the highest one met is the code
      for (int k = 1; k < 256; k++) begin
         thr = srgb_mode ? SRGB_TABLE[8'(k)] : LINEAR_TABLE[8'(k)];
         if (sample_bits[30:0] >= thr[30:0]) begin
            acc = 8'(k);
         end
      end
      code = zero_code ? 8'd0 : acc;
   end

endmodule

// ===== rtl/f2u8s_checker.sv =====
// ----------------------------------------------------------------------------
// f2u8s_checker: port-level checks for the encoder core
// backpressure, stall hold and reset behavior seen on the ports
// ----------------------------------------------------------------------------
module f2u8s_checker
   import f2u8s_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_ready,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input rsp_payload_type rsp_payload
);

   // no result straight after reset
   a_reset_empty: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // input side only stalls when the result side is full and stalled
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("input stalled without output backpressure");

   // a stalled result stays
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result dropped while stalled");

   // a stalled result keeps its value
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> $stable(rsp_payload))
      else $error("result changed while stalled");

endmodule

bind float_to_unorm8_srgb_encode_core f2u8s_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for float_to_unorm8_srgb_encode_core
// streams binary32 samples through linear and sRGB encode with random
// sender gaps and receiver stalls; every 8-bit code and last flag is checked
// against a typed-in code or an exact integer model of the encode kept in this bench
// ----------------------------------------------------------------------------
module tb;
   import f2u8s_pkg::*;

   localparam bit          MODE_LINEAR    = 1'b0;
   localparam bit          MODE_SRGB      = 1'b1;
   localparam int          MAX_WAIT       = 16;
   localparam int          HOLD_CYCLES    = 300;
   localparam int          STALL_LIMIT    = 1000;
   localparam int          PHASE_ITEMS    = 300;
   localparam int          NUM_PHASES     = 6;
   localparam int          FROM_PREDICTOR = -1;
   localparam int          NUM_ROWS       = 24;
   localparam logic [31:0] POS_INF        = 32'h7F80_0000;
   // binary32 closest to 0.0031308, where the sRGB curve changes segment
   localparam logic [31:0] SRGB_KNEE      = 32'h3B4D_2E1C;

   // block ports, inputs known from time zero
   logic            clock       = 1'b0;
   logic            reset       = 1'b1;
   logic            req_valid   = 1'b0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready   = 1'b0;
   rsp_payload_type rsp_payload;
   logic            csr_wr_en   = 1'b0;
   logic            csr_wr_data = 1'b0;

   // bench copy of the mode bit, changed only while the block is drained
   bit              srgb_sel         = MODE_LINEAR;
   rsp_payload_type expected_codes[$];
   int              samples_sent     = 0;
   int              codes_seen       = 0;
   int              mismatches       = 0;
   int              idle_cycles      = 0;
   int              sender_burst     = 0;
   int              receiver_burst   = 0;
   bit              hold_off_request = 1'b0;

   typedef struct {
      bit          mode;
      logic [31:0] sample;
      bit          last;
      int          known_code;
   } sample_row_type;

   // directed rows: typed-in codes only where they are obvious
   sample_row_type directed_rows[NUM_ROWS] = '{
      // linear mode, straight out of reset (no register write yet)
      '{MODE_LINEAR, 32'h0000_0000, 1'b0, 0},              // +0
      '{MODE_LINEAR, 32'h8000_0000, 1'b0, 0},              // -0
      '{MODE_LINEAR, 32'hFFFF_FFFF, 1'b0, 0},              // negative nan
      '{MODE_LINEAR, 32'h7FC0_0000, 1'b0, 0},              // quiet nan
      '{MODE_LINEAR, 32'h7F80_0001, 1'b0, 0},              // smallest nan payload
      '{MODE_LINEAR, POS_INF,       1'b1, 255},            // +inf
      '{MODE_LINEAR, ONE_BITS,      1'b0, 255},            // exactly 1.0
      '{MODE_LINEAR, 32'h7F7F_FFFF, 1'b0, 255},            // largest finite
      '{MODE_LINEAR, 32'h0000_0001, 1'b0, 0},              // smallest subnormal
      '{MODE_LINEAR, 32'h007F_FFFF, 1'b0, 0},              // largest subnormal
      '{MODE_LINEAR, 32'h3F7F_FFFF, 1'b0, FROM_PREDICTOR}, // just below 1.0
      '{MODE_LINEAR, 32'h3F00_0000, 1'b0, FROM_PREDICTOR}, // 0.5, a half step
      '{MODE_LINEAR, 32'h3B80_8081, 1'b0, FROM_PREDICTOR}, // near 1/255
      '{MODE_LINEAR, 32'h3E80_0000, 1'b1, FROM_PREDICTOR}, // 0.25
      // sRGB mode
      '{MODE_SRGB,   32'h0000_0000, 1'b0, 0},
      '{MODE_SRGB,   32'hBF80_0000, 1'b0, 0},              // -1.0
      '{MODE_SRGB,   32'h7FFF_FFFF, 1'b0, 0},              // nan, all ones payload
      '{MODE_SRGB,   POS_INF,       1'b0, 255},
      '{MODE_SRGB,   ONE_BITS,      1'b1, 255},
      '{MODE_SRGB,   32'h007F_FFFF, 1'b0, 0},              // subnormal, linear segment
      '{MODE_SRGB,   SRGB_KNEE,     1'b0, FROM_PREDICTOR}, // first power-segment value
      '{MODE_SRGB,   SRGB_KNEE + 1, 1'b0, FROM_PREDICTOR}, // power segment, one step above the knee
      '{MODE_SRGB,   32'h3F00_0000, 1'b0, FROM_PREDICTOR},
      '{MODE_SRGB,   32'h3F7F_FFFF, 1'b1, FROM_PREDICTOR}
   };

   float_to_unorm8_srgb_encode_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // period 2
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // code prediction, exact integer arithmetic
   // ------------------------------------------------------------------

   // linear: x*255 rounded once to 24 bits, then half away from zero
   function automatic logic [7:0] linear_code(logic [23:0] mant, int neg_e);
      logic [63:0] prod;
      logic [63:0] q;
      logic [63:0] rem;
      logic [63:0] half;
      int          top;
      int          drop;
      int          sh;
      if (mant == 24'd0) begin
         return 8'd0;
      end
      prod = 64'(mant) * 64'd255;
      top  = 0;
      for (int i = 0; i < 64; i++) begin
         if (prod[i]) begin
            top = i;
         end
      end
      // single-precision rounding of the product, nearest even
      drop = (top >= 24) ? top - 23 : 0;
      q    = prod >> drop;
      if (drop > 0) begin
         rem  = prod & ((64'd1 << drop) - 64'd1);
         half = 64'd1 << (drop - 1);
         if (rem > half || (rem == half && q[0])) begin
            q = q + 64'd1;
         end
      end
      sh = neg_e - drop;
      if (sh > 40) begin
         return 8'd0;
      end
      if (sh > 0) begin
         q = (q + (64'd1 << (sh - 1))) >> sh;
      end
      return (q > 64'd255) ? 8'd255 : q[7:0];
   endfunction

   // power segment: level k is reached when x^5 * 53805^12 >= (200k+2705)^12
   function automatic bit srgb_level_met(logic [383:0] scaled_x5, int neg_e, int k);
      logic [383:0] bound;
      bound = 384'd1;
      repeat (12) bound = bound * 384'(200 * k + 2705);
      bound = bound << (5 * neg_e);
      return scaled_x5 >= bound;
   endfunction

   function automatic logic [7:0] srgb_code(logic [23:0] mant, int neg_e);
      logic [383:0] scaled_x5;
      logic [63:0]  num;
      logic [63:0]  den;
      bit           on_linear_seg;
      int           lo;
      int           hi;
      int           mid;
      if (mant == 24'd0) begin
         return 8'd0;
      end
      if (neg_e >= 40) begin
         on_linear_seg = 1'b1;
      end else begin
         on_linear_seg = (64'(mant) * 64'd10000000) <= (64'd31308 << neg_e);
      end
      if (on_linear_seg) begin
         if (neg_e >= 37) begin
            return 8'd0;
         end
         // x * 12.92 * 255 = x * 3294.6, rounded half up
         num = 64'(mant) * 64'd32946;
         den = 64'd10 << neg_e;
         return 8'((2 * num + den) / (2 * den));
      end
      scaled_x5 = 384'd1;
      repeat (5) scaled_x5 = scaled_x5 * 384'(mant);
      repeat (12) scaled_x5 = scaled_x5 * 384'd53805;
      // largest level that is met
      lo = 0;
      hi = 255;
      while (lo < hi) begin
         mid = (lo + hi + 1) / 2;
         if (srgb_level_met(scaled_x5, neg_e, mid)) begin
            lo = mid;
         end else begin
            hi = mid - 1;
         end
      end
      return 8'(lo);
   endfunction

   function automatic logic [7:0] encode_code(logic [31:0] sample, bit srgb);
      logic [23:0] mant;
      int          neg_e;
      // negatives, -0 and negative nan
      if (sample[31]) begin
         return 8'd0;
      end
      // nan gives 0, +inf saturates
      if (sample[30:23] == 8'hFF) begin
         return (sample[22:0] != 23'd0) ? 8'd0 : 8'd255;
      end
      if (sample >= ONE_BITS) begin
         return 8'd255;
      end
      if (sample[30:23] == 8'd0) begin
         mant  = {1'b0, sample[22:0]};
         neg_e = 149;
      end else begin
         mant  = {1'b1, sample[22:0]};
         neg_e = 150 - int'(sample[30:23]);
      end
      return srgb ? srgb_code(mant, neg_e) : linear_code(mant, neg_e);
   endfunction

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------

   // wait length per item, with occasional runs of back-to-back items
   function automatic int draw_wait(inout int burst_left);
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0) begin
         burst_left = $urandom_range(20, 60);
         return 0;
      end
      return $urandom_range(0, MAX_WAIT);
   endfunction

   // mostly the unit interval, where the codes actually vary
   function automatic logic [31:0] random_sample();
      logic [22:0] frac;
      logic [7:0]  expo;
      int          pick;
      frac = 23'($urandom());
      if ($urandom_range(0, 3) == 0) begin
         frac[11:0] = '0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         if ($urandom_range(0, 3) == 0) begin
            expo = 8'($urandom_range(0, 126));
         end else begin
            expo = 8'($urandom_range(112, 126));
         end
         return {1'b0, expo, frac};
      end
      if (pick < 65) begin
         // around the segment change of the sRGB curve
         return SRGB_KNEE + 32'($urandom_range(0, 64)) - 32'd32;
      end
      if (pick < 80) begin
         return $urandom();
      end
      if (pick < 90) begin
         case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'h8000_0000;
            2: return POS_INF;
            3: return ONE_BITS;
            4: return ONE_BITS - 32'd1;
            5: return 32'h7FC0_0000;
            6: return 32'h007F_FFFF;
            default: return 32'h0000_0001;
         endcase
      end
      // at or above 1.0, either sign
      expo = 8'($urandom_range(127, 254));
      return {1'($urandom_range(0, 1)), expo, frac};
   endfunction

   // offer one sample and hold it until the transfer; expectation is
   // queued at the transfer edge
   task automatic send_sample(input logic [31:0] sample, input bit last,
                              input int known_code);
      int              gap;
      rsp_payload_type want;
      gap = draw_wait(sender_burst);
      if (known_code == FROM_PREDICTOR) begin
         want.code_out = encode_code(sample, srgb_sel);
      end else begin
         want.code_out = 8'(known_code);
      end
      want.last_out = last;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{sample_bits: sample, last_in: last};
      // ready is settled by the falling edge; the next rising edge is the
      // transfer once it reads high there
      @(negedge clock);
      while (!req_ready) @(negedge clock);
      @(posedge clock);
      expected_codes.push_back(want);
      samples_sent++;
   endtask

   // stop offering and let every queued code come out, plus pipeline slack
   task automatic drain_codes();
      req_valid <= 1'b0;
      while (codes_seen != samples_sent) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_mode(input bit mode);
      drain_codes();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mode;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      srgb_sel = mode;
   endtask

   // ------------------------------------------------------------------
   // sender: directed table, then random phases alternating the mode
   // ------------------------------------------------------------------
   initial begin : stimulus
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].mode != srgb_sel) begin
            write_mode(directed_rows[i].mode);
         end
         send_sample(directed_rows[i].sample, directed_rows[i].last,
                     directed_rows[i].known_code);
      end

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         write_mode((phase % 2 == 0) ? MODE_SRGB : MODE_LINEAR);
         if (phase == 1) begin
            // receiver goes quiet while the sender keeps pushing, so the
            // pipeline fills and the input side has to stall
            hold_off_request = 1'b1;
            sender_burst     = 80;
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            send_sample(random_sample(), $urandom_range(0, 15) == 0, FROM_PREDICTOR);
         end
      end

      drain_codes();
      if (mismatches == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

   // ------------------------------------------------------------------
   // receiver: random stalls per result, one long hold-off on request
   // ------------------------------------------------------------------
   initial begin : receiver
      int stall;
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            stall            = HOLD_CYCLES;
         end else begin
            stall = draw_wait(receiver_burst);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         // wait for a result that is valid ahead of a rising edge
         @(negedge clock);
         while (!rsp_valid) @(negedge clock);
         @(posedge clock);
      end
   end

   // ------------------------------------------------------------------
   // result check: each transfer against the oldest queued code
   // ------------------------------------------------------------------
   always @(posedge clock) begin : check_codes
      rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         codes_seen++;
         if (expected_codes.size() == 0) begin
            $display("%0t: unexpected result, code %0d last %0b", $time,
                     rsp_payload.code_out, rsp_payload.last_out);
            mismatches++;
         end else begin
            want = expected_codes.pop_front();
            if (rsp_payload.code_out !== want.code_out) begin
               $display("%0t: code_out expected %0d actual %0d", $time,
                        want.code_out, rsp_payload.code_out);
               mismatches++;
            end
            if (rsp_payload.last_out !== want.last_out) begin
               $display("%0t: last_out expected %0b actual %0b", $time,
                        want.last_out, rsp_payload.last_out);
               mismatches++;
            end
         end
      end
   end

   // watchdog: too long without any transfer on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end
   end

endmodule

// ===== float_to_unorm8_srgb_encode_core.f =====
rtl/f2u8s_pkg.sv
rtl/f2u8s_encode.sv
rtl/float_to_unorm8_srgb_encode_core.sv
rtl/f2u8s_checker.sv
bench/tb.sv
